// ===== src/flr_pkg.sv =====
// Package for the firmware record loader: job and command types, register
// constants and the transfer-setup value table.
// No dependencies.
package flr_pkg;

  localparam logic [31:0] SetupBase = 32'h0000_1c11;
  localparam logic [31:0] BusyReg   = 32'h0000_1c1a;
  localparam logic [31:0] DataPort  = 32'h0001_1800;
  localparam logic [31:0] HalfBase  = 32'h0000_1000;

  localparam logic [15:0] FlagsWord  = 16'd1;
  localparam logic [15:0] FlagsHalf  = 16'd2;
  localparam logic [15:0] FlagsXfer  = 16'd4;
  localparam logic [15:0] FlagsEnd   = 16'd0;

  localparam logic [3:0] HdrLast    = 4'd9;
  localparam logic [3:0] SetupSteps = 4'd10;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_WAIT  = 2'd1,
    KIND_END   = 2'd2
  } cmd_kind_e;

  typedef enum logic [1:0] {
    JOB_WRITE = 2'd0,
    JOB_SETUP = 2'd1,
    JOB_END   = 2'd2
  } job_op_e;

  // For a setup job, addr carries the doubled offset and data the byte count.
  typedef struct packed {
    job_op_e     op;
    logic [31:0] addr;
    logic [31:0] data;
    logic        add_wait;
  } job_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic        last;
  } cmd_t;

  function automatic logic [31:0] setup_value(input logic [3:0]  step,
                                              input logic [31:0] off2,
                                              input logic [31:0] len);
    logic [31:0] v;
    v = '0;
    unique case (step)
      4'd0, 4'd7:       v = {16'd0, off2[15:0]};
      4'd1, 4'd8:       v = {16'd0, off2[31:16]};
      4'd2, 4'd3:       v = len;
      4'd5, 4'd6, 4'd9: v = 32'd1;
      default:          v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/flr_front.sv =====
// Front end of the firmware record loader: parses headers and payload bytes
// and turns each byte into at most one job. Depends on flr_pkg.
module flr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          byte_valid_i,
  output logic          byte_ready_o,
  input  logic [7:0]    byte_i,
  input  logic          end_i,
  input  logic          queue_full_i,
  output logic          push_o,
  output flr_pkg::job_t job_o
);
  import flr_pkg::*;

  logic [3:0]  hdr_idx_q, hdr_idx_d;
  logic        in_pay_q, in_pay_d;
  logic        stopped_q, stopped_d;
  logic [15:0] flags_q, flags_d;
  logic [31:0] offset_q, offset_d;
  logic [31:0] len_q, len_d;
  logic [31:0] pidx_q, pidx_d;
  logic [23:0] held_q, held_d;
  logic [31:0] base_q, base_d;

  logic        accept;
  logic [31:0] len_full, len2, word, pidx_inc;
  logic        is_half, active, last, emit;
  logic [1:0]  pos;

  assign byte_ready_o = !queue_full_i;
  assign accept       = byte_valid_i && byte_ready_o;

  assign len_full = {byte_i, len_q[23:0]};
  assign len2     = {len_full[30:0], 1'b0};
  assign pidx_inc = pidx_q + 32'd1;

  assign is_half = (flags_q == FlagsHalf);
  assign active  = (flags_q == FlagsWord) || is_half || (flags_q == FlagsXfer);
  assign pos     = is_half ? {1'b0, pidx_q[0]} : pidx_q[1:0];
  assign last    = (pidx_inc == len_q);
  assign emit    = active && (last || (pos == (is_half ? 2'd1 : 2'd3)));
  // Bytes above the current position are always zero in the held word.
  assign word    = {8'd0, held_q} | ({24'd0, byte_i} << {pos, 3'b000});

  always_comb begin
    hdr_idx_d = hdr_idx_q;
    in_pay_d  = in_pay_q;
    stopped_d = stopped_q;
    flags_d   = flags_q;
    offset_d  = offset_q;
    len_d     = len_q;
    pidx_d    = pidx_q;
    held_d    = held_q;
    base_d    = base_q;
    push_o    = 1'b0;
    job_o     = '{op: JOB_WRITE, addr: '0, data: '0, add_wait: 1'b0};

    if (accept && !stopped_q) begin
      if (in_pay_q) begin
        if (active) begin
          held_d = emit ? 24'd0 : word[23:0];
        end
        push_o = emit;
        job_o.add_wait = last && (flags_q == FlagsXfer);
        priority if (flags_q == FlagsWord) begin
          job_o.addr = base_q + {2'b00, pidx_q[31:2]};
          job_o.data = {word[15:8], word[7:0], word[31:24], word[23:16]};
        end else if (is_half) begin
          job_o.addr = base_q + {1'b0, pidx_q[31:1]};
          job_o.data = {16'd0, word[15:8], word[7:0]};
        end else begin
          job_o.addr = DataPort;
          job_o.data = {word[23:16], word[31:24], word[7:0], word[15:8]};
        end
        if (last) begin
          in_pay_d = 1'b0;
          pidx_d   = '0;
          held_d   = '0;
        end else begin
          pidx_d = pidx_inc;
        end
      end else begin
        unique case (hdr_idx_q)
          4'd0:    flags_d[7:0]    = byte_i;
          4'd1:    flags_d[15:8]   = byte_i;
          4'd2:    offset_d[7:0]   = byte_i;
          4'd3:    offset_d[15:8]  = byte_i;
          4'd4:    offset_d[23:16] = byte_i;
          4'd5:    offset_d[31:24] = byte_i;
          4'd6:    len_d[7:0]      = byte_i;
          4'd7:    len_d[15:8]     = byte_i;
          4'd8:    len_d[23:16]    = byte_i;
          default: len_d           = len2;
        endcase
        if (hdr_idx_q == HdrLast) begin
          hdr_idx_d = '0;
          pidx_d    = '0;
          held_d    = '0;
          base_d    = is_half ? (HalfBase + offset_q) : {1'b0, offset_q[31:1]};
          if (flags_q == FlagsEnd) begin
            stopped_d = 1'b1;
            in_pay_d  = 1'b0;
            push_o    = 1'b1;
            job_o.op  = JOB_END;
          end else begin
            in_pay_d = (len2 != 32'd0);
            if (flags_q == FlagsXfer) begin
              push_o         = 1'b1;
              job_o.op       = JOB_SETUP;
              job_o.addr     = {offset_q[30:0], 1'b0};
              job_o.data     = len2;
              job_o.add_wait = (len2 == 32'd0);
            end
          end
        end else begin
          hdr_idx_d = hdr_idx_q + 4'd1;
        end
      end
    end

    // The last beat of an image drops any partial record.
    if (accept && end_i) begin
      hdr_idx_d = '0;
      in_pay_d  = 1'b0;
      pidx_d    = '0;
      held_d    = '0;
      stopped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_idx_q <= '0;
      in_pay_q  <= 1'b0;
      stopped_q <= 1'b0;
      flags_q   <= '0;
      offset_q  <= '0;
      len_q     <= '0;
      pidx_q    <= '0;
      held_q    <= '0;
    end else begin
      hdr_idx_q <= hdr_idx_d;
      in_pay_q  <= in_pay_d;
      stopped_q <= stopped_d;
      flags_q   <= flags_d;
      offset_q  <= offset_d;
      len_q     <= len_d;
      pidx_q    <= pidx_d;
      held_q    <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
  end

endmodule

// ===== src/flr_queue.sv =====
// Short job queue between the parser front end and the command back end.
// Depends on flr_pkg.
module flr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  flr_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output flr_pkg::job_t head_o
);
  import flr_pkg::*;

  job_t             slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o       = (count_q == QCntW'(QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== src/flr_back.sv =====
// Back end of the firmware record loader (needs flr_pkg): expands queued jobs
// into register commands in an output register, one per cycle unless stalled.
module flr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  flr_pkg::job_t head_i,
  output logic          pop_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output flr_pkg::cmd_t cmd_o
);
  import flr_pkg::*;

  logic [3:0] step_q;
  logic [3:0] last_step;
  logic       out_valid_q;
  cmd_t       out_q, cmd_d;
  logic       load, is_wait;

  assign last_step = ((head_i.op == JOB_SETUP) ? (SetupSteps - 4'd1) : 4'd0)
                   + {3'b000, head_i.add_wait};
  assign load      = head_valid_i && (!out_valid_q || cmd_ready_i);
  assign pop_o     = load && (step_q == last_step);
  assign is_wait   = head_i.add_wait && (step_q == last_step);

  always_comb begin
    cmd_d      = '{kind: KIND_WRITE, addr: '0, data: '0, last: 1'b0};
    cmd_d.last = (step_q == last_step);
    if (is_wait) begin
      cmd_d.kind = KIND_WAIT;
      cmd_d.addr = BusyReg;
    end else begin
      unique case (head_i.op)
        JOB_END: begin
          cmd_d.kind = KIND_END;
        end
        JOB_SETUP: begin
          cmd_d.addr = SetupBase + {28'd0, step_q};
          cmd_d.data = setup_value(step_q, head_i.addr, head_i.data);
        end
        default: begin
          cmd_d.addr = head_i.addr;
          cmd_d.data = head_i.data;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        step_q <= '0;
      end else if (load) begin
        step_q <= step_q + 4'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (cmd_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= cmd_d;
    end
  end

  assign cmd_valid_o = out_valid_q;
  assign cmd_o       = out_q;

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> step_q <= last_step)
    else $error("command step ran past the end of its job");

  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KIND_END) |->
      (out_q.addr == 32'd0 && out_q.data == 32'd0 && out_q.last))
    else $error("end command carries address or data");

  a_wait_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KIND_WAIT) |->
      (out_q.addr == BusyReg && out_q.data == 32'd0 && out_q.last))
    else $error("wait command malformed or not last of its burst");

endmodule

// ===== src/firmware_record_loader.sv =====
// Top level of the firmware record loader: parser front end, job queue and
// command back end. Depends on flr_pkg, flr_front, flr_queue and flr_back.
//
// The loader takes one image byte per beat and emits register commands. A
// byte is taken every cycle as long as the two-entry job queue has room; most
// bytes cause no command or one. The back end sends one command per cycle
// while the output is not stalled, so a type-4 record's header, which expands
// into ten setup writes (eleven with the wait for an empty payload), can hold
// the input until the queue has room, and the byte that ends a type-4 payload
// yields a data write and then a wait. Bytes pass through the job queue and
// the output register; a stalled output fills the queue and holds the input.
module firmware_record_loader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // image_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [31:0] reg_address, [63:32] reg_data
  output logic [1:0]  m_axis_tuser_o,   // [1:0] command_kind
  output logic        m_axis_tlast_o    // final_of_burst
);
  import flr_pkg::*;

  logic queue_full, push, pop, head_valid;
  job_t push_job, head;
  cmd_t cmd;

  flr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_ready_o (s_axis_tready_o),
    .byte_i       (s_axis_tdata_i),
    .end_i        (s_axis_tlast_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  flr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  flr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .cmd_valid_o  (m_axis_tvalid_o),
    .cmd_ready_i  (m_axis_tready_i),
    .cmd_o        (cmd)
  );

  assign m_axis_tdata_o = {cmd.data, cmd.addr};
  assign m_axis_tuser_o = cmd.kind;
  assign m_axis_tlast_o = cmd.last;

endmodule
